@@ sv/wrs_pkg.sv @@
package wrs_pkg;

  localparam int unsigned ITEM_COUNT  = 7;
  localparam int unsigned WEIGHT_REGS = 7;

  localparam int unsigned STATE_W = 32;
  localparam int unsigned WEIGHT_W = 8;
  localparam int unsigned TOTAL_W = 11;
  localparam int unsigned DRAW_W = 15;
  localparam int unsigned INDEX_W = 3;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [STATE_W-1:0] LCG_MUL = 32'h0003_43FD;
  localparam logic [STATE_W-1:0] LCG_ADD = 32'h0026_9EC3;
  localparam logic [STATE_W-1:0] GEN_RESET = 32'd1;
  localparam int unsigned DRAW_SHIFT = 16;

  localparam logic KIND_SEED = 1'b0;
  localparam logic KIND_DRAW = 1'b1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [WEIGHT_REGS] = '{
    8'd20, 8'd20, 8'd20, 8'd20, 8'd5, 8'd5, 8'd1
  };

endpackage

@@ sv/wrs_mod.sv @@
module wrs_mod (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [wrs_pkg::DRAW_W-1:0]   dividend_i,
  input  logic [wrs_pkg::TOTAL_W-1:0]  divisor_i,
  output logic                         done_o,
  output logic [wrs_pkg::TOTAL_W-1:0]  remainder_o
);
  import wrs_pkg::*;

  localparam int unsigned CNT_W = $clog2(DRAW_W);

  logic [TOTAL_W-1:0] rem_q, rem_d;
  logic [DRAW_W-1:0]  num_q;
  logic [TOTAL_W-1:0] div_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [TOTAL_W:0]   trial;
  logic [TOTAL_W:0]   diff;

  // one restoring step per cycle, dividend msb first
  always_comb begin
    trial = {rem_q, num_q[DRAW_W-1]};
    diff  = trial - {1'b0, div_q};
    if (trial >= {1'b0, div_q}) begin
      rem_d = diff[TOTAL_W-1:0];
    end else begin
      rem_d = trial[TOTAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      num_q  <= '0;
      div_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        num_q  <= dividend_i;
        div_q  <= divisor_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_d;
        num_q <= {num_q[DRAW_W-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DRAW_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o      = done_q;
  assign remainder_o = rem_q;

endmodule

@@ sv/weighted_random_selector.sv @@
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_ready_o   kind_i, seed_value_i
// out      output     out_valid_o / out_ready_i item_index_o, draw_value_o,
//                                               weight_total_o, no_weight_o
// cfg      input      cfg_we_i                  cfg_addr_i, cfg_data_i
//
// a seed beat loads the generator state and gives no result
// a draw runs from accept to result through multiply, add and total,
// 15 steps of the serial remainder unit, then the wheel search
// with zero total weight the remainder unit is skipped
// async active-low reset: generator state 1, weights to their defaults
// a held result stalls only the final search step; input stays closed meanwhile
module weighted_random_selector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             kind_i,
  input  logic [wrs_pkg::STATE_W-1:0]      seed_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [wrs_pkg::INDEX_W-1:0]      item_index_o,
  output logic [wrs_pkg::TOTAL_W-1:0]      draw_value_o,
  output logic [wrs_pkg::TOTAL_W-1:0]      weight_total_o,
  output logic                             no_weight_o,
  input  logic                             cfg_we_i,
  input  logic [wrs_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [wrs_pkg::WEIGHT_W-1:0]     cfg_data_i
);
  import wrs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_ADD,
    S_DIV,
    S_PICK
  } state_e;

  state_e              state_q;
  logic [WEIGHT_W-1:0] weight_q [WEIGHT_REGS];
  logic [STATE_W-1:0]  gen_q;
  logic [STATE_W-1:0]  gen_d;
  logic [STATE_W-1:0]  product_q;
  logic [TOTAL_W-1:0]  total_q;
  logic                zero_q;
  logic [TOTAL_W-1:0]  total_sum;
  logic                div_start;
  logic                div_done;
  logic [TOTAL_W-1:0]  div_rem;
  logic [TOTAL_W-1:0]  draw_val;
  logic [TOTAL_W-1:0]  running;
  logic [INDEX_W-1:0]  pick;
  logic                found;
  logic                out_free;

  logic                out_valid_q;
  logic [INDEX_W-1:0]  item_index_q;
  logic [TOTAL_W-1:0]  draw_value_q;
  logic [TOTAL_W-1:0]  weight_total_q;
  logic                no_weight_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WEIGHT_REGS; i++) begin
        weight_q[i] <= WEIGHT_RESET[i];
      end
    end else if (cfg_we_i && (32'(cfg_addr_i) < WEIGHT_REGS)) begin
      weight_q[cfg_addr_i] <= cfg_data_i;
    end
  end

  always_comb begin
    total_sum = '0;
    for (int i = 0; i < ITEM_COUNT; i++) begin
      total_sum = total_sum + TOTAL_W'(weight_q[i]);
    end
  end

  assign gen_d     = product_q + LCG_ADD;
  assign div_start = (state_q == S_ADD) && (total_sum != '0);

  wrs_mod u_mod (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (gen_d[DRAW_SHIFT +: DRAW_W]),
    .divisor_i   (total_sum),
    .done_o      (div_done),
    .remainder_o (div_rem)
  );

  // roulette wheel: first item whose running sum reaches the draw
  always_comb begin
    draw_val = div_rem + 1'b1;
    running  = '0;
    pick     = '0;
    found    = 1'b0;
    for (int i = 0; i < ITEM_COUNT; i++) begin
      running = running + TOTAL_W'(weight_q[i]);
      if (!found && (running >= draw_val)) begin
        pick  = INDEX_W'(i);
        found = 1'b1;
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      gen_q          <= GEN_RESET;
      product_q      <= '0;
      total_q        <= '0;
      zero_q         <= 1'b0;
      out_valid_q    <= 1'b0;
      item_index_q   <= '0;
      draw_value_q   <= '0;
      weight_total_q <= '0;
      no_weight_q    <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != S_PICK)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (kind_i == KIND_SEED) begin
              gen_q <= seed_value_i;
            end else begin
              state_q <= S_STEP;
            end
          end
        end
        S_STEP: begin
          product_q <= gen_q * LCG_MUL;
          state_q   <= S_ADD;
        end
        S_ADD: begin
          gen_q   <= gen_d;
          total_q <= total_sum;
          zero_q  <= (total_sum == '0);
          if (total_sum == '0) begin
            state_q <= S_PICK;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_PICK;
          end
        end
        S_PICK: begin
          if (out_free) begin
            out_valid_q    <= 1'b1;
            weight_total_q <= total_q;
            no_weight_q    <= zero_q;
            if (zero_q) begin
              item_index_q <= '0;
              draw_value_q <= '0;
            end else begin
              item_index_q <= pick;
              draw_value_q <= draw_val;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign item_index_o   = item_index_q;
  assign draw_value_o   = draw_value_q;
  assign weight_total_o = weight_total_q;
  assign no_weight_o    = no_weight_q;

endmodule

@@ test/wrs_pick_checker.sv @@
module wrs_pick_checker
  import wrs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  kind_i,
  input  logic [STATE_W-1:0]    seed_value_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [INDEX_W-1:0]    item_index_i,
  input  logic [TOTAL_W-1:0]    draw_value_i,
  input  logic [TOTAL_W-1:0]    weight_total_i,
  input  logic                  no_weight_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [WEIGHT_W-1:0]   cfg_data_i,
  output int                    pending_o,
  output int                    errors_o
);

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [TOTAL_W-1:0] draw;
    logic [TOTAL_W-1:0] total;
    logic               empty;
  } pick_t;

  logic [STATE_W-1:0]  lcg_state;
  logic [WEIGHT_W-1:0] weights [WEIGHT_REGS];
  pick_t               picks_q [$];
  int                  err_count;

  assign errors_o = err_count;

  task automatic report(input string msg);
    $display("%0t: pick mismatch: %s", $time, msg);
    err_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [STATE_W-1:0] nxt;
    logic [DRAW_W-1:0]  r;
    int                 total;
    int                 draw;
    int                 running;
    bit                 found;
    pick_t              want;
    pick_t              got;
    if (!rst_ni) begin
      lcg_state = GEN_RESET;
      for (int i = 0; i < WEIGHT_REGS; i++) weights[i] = WEIGHT_RESET[i];
      picks_q.delete();
      err_count = 0;
    end else begin
      if (cfg_we_i && cfg_addr_i < WEIGHT_REGS) weights[cfg_addr_i] = cfg_data_i;

      if (in_valid_i && in_ready_i) begin
        if (kind_i == KIND_SEED) begin
          lcg_state = seed_value_i;
        end else begin
          nxt = lcg_state * LCG_MUL + LCG_ADD;
          lcg_state = nxt;
          r = nxt[DRAW_SHIFT +: DRAW_W];
          total = 0;
          for (int i = 0; i < ITEM_COUNT; i++) total += weights[i];
          want = '0;
          if (total == 0) begin
            want.empty = 1'b1;
          end else begin
            draw = int'(r) % total + 1;
            running = 0;
            found = 1'b0;
            for (int i = 0; i < ITEM_COUNT; i++) begin
              running += weights[i];
              if (!found && running >= draw) begin
                want.index = INDEX_W'(i);
                found = 1'b1;
              end
            end
            want.draw = TOTAL_W'(draw);
            want.total = TOTAL_W'(total);
          end
          picks_q.push_back(want);
        end
      end

      if (out_valid_i && out_ready_i) begin
        got = '{item_index_i, draw_value_i, weight_total_i, no_weight_i};
        if (picks_q.size() == 0) begin
          report($sformatf("result beat with nothing expected (index %0d)", got.index));
        end else begin
          want = picks_q.pop_front();
          if (got.index !== want.index)
            report($sformatf("item_index got %0d want %0d", got.index, want.index));
          if (got.draw !== want.draw)
            report($sformatf("draw_value got %0d want %0d", got.draw, want.draw));
          if (got.total !== want.total)
            report($sformatf("weight_total got %0d want %0d", got.total, want.total));
          if (got.empty !== want.empty)
            report($sformatf("no_weight got %0b want %0b", got.empty, want.empty));
        end
      end
    end
    pending_o <= picks_q.size();
  end

endmodule

@@ test/tb_weighted_random_selector.sv @@
module tb_weighted_random_selector;
  import wrs_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 1000;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned PHASES        = 8;
  localparam int unsigned PHASE_ITEMS   = 112;

  typedef logic [WEIGHT_W-1:0] wheel_t [WEIGHT_REGS];

  typedef enum int {
    WHEEL_FULL,
    WHEEL_SPARSE,
    WHEEL_TINY,
    WHEEL_SINGLE,
    WHEEL_MAX,
    WHEEL_SCARCE
  } wheel_mode_e;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  kind_i       = KIND_SEED;
  logic [STATE_W-1:0]    seed_value_i = '0;
  logic                  out_ready_i  = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i   = '0;
  logic [WEIGHT_W-1:0]   cfg_data_i   = '0;

  logic                  in_ready_o;
  logic                  out_valid_o;
  logic [INDEX_W-1:0]    item_index_o;
  logic [TOTAL_W-1:0]    draw_value_o;
  logic [TOTAL_W-1:0]    weight_total_o;
  logic                  no_weight_o;

  int                    pending;
  int                    errors;
  bit                    calm = 1'b0;
  int unsigned           quiet_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  weighted_random_selector uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .seed_value_i   (seed_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .item_index_o   (item_index_o),
    .draw_value_o   (draw_value_o),
    .weight_total_o (weight_total_o),
    .no_weight_o    (no_weight_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i)
  );

  wrs_pick_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .kind_i         (kind_i),
    .seed_value_i   (seed_value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .item_index_i   (item_index_o),
    .draw_value_i   (draw_value_o),
    .weight_total_i (weight_total_o),
    .no_weight_i    (no_weight_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_data_i     (cfg_data_i),
    .pending_o      (pending),
    .errors_o       (errors)
  );

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb_weighted_random_selector: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic kind, input logic [STATE_W-1:0] seed);
    if (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    seed_value_i <= seed;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold the sender until every pick is back and the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_weights(input wheel_t wheel);
    for (int i = 0; i < WEIGHT_REGS; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= CFG_ADDR_W'(i);
      cfg_data_i <= wheel[i];
      @(posedge clk_i);
    end
    // index past the wheel, must be ignored
    cfg_addr_i <= CFG_ADDR_W'(WEIGHT_REGS);
    cfg_data_i <= WEIGHT_W'($urandom_range(255));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    wheel_t      wheel;
    wheel_mode_e mode;
    int          hot;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset weights: reset generator state, then seeds zero, all ones and top bit only
    send_beat(KIND_DRAW, $urandom);
    send_beat(KIND_DRAW, $urandom);
    send_beat(KIND_SEED, '0);
    send_beat(KIND_DRAW, $urandom);
    send_beat(KIND_SEED, '1);
    send_beat(KIND_DRAW, $urandom);
    send_beat(KIND_SEED, 32'h8000_0000);
    send_beat(KIND_DRAW, $urandom);

    // zero total weight
    settle();
    wheel = '{default: '0};
    load_weights(wheel);
    send_beat(KIND_DRAW, $urandom);
    send_beat(KIND_DRAW, $urandom);

    // largest total
    settle();
    wheel = '{default: '1};
    load_weights(wheel);
    send_beat(KIND_DRAW, $urandom);
    send_beat(KIND_DRAW, $urandom);

    // only the last item, only the first, and zero weights in between
    settle();
    wheel = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1};
    load_weights(wheel);
    send_beat(KIND_DRAW, $urandom);
    settle();
    wheel = '{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    load_weights(wheel);
    send_beat(KIND_DRAW, $urandom);
    settle();
    wheel = '{8'd0, 8'd3, 8'd0, 8'd0, 8'd7, 8'd0, 8'd0};
    load_weights(wheel);
    send_beat(KIND_DRAW, $urandom);
    send_beat(KIND_DRAW, $urandom);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      mode = wheel_mode_e'((phase < 6) ? phase : $urandom_range(5));
      hot = $urandom_range(WEIGHT_REGS - 1);
      for (int k = 0; k < WEIGHT_REGS; k++) begin
        case (mode)
          WHEEL_FULL:   wheel[k] = WEIGHT_W'($urandom_range(255));
          WHEEL_SPARSE: wheel[k] = $urandom_range(1) ? WEIGHT_W'($urandom_range(255)) : '0;
          WHEEL_TINY:   wheel[k] = WEIGHT_W'($urandom_range(3));
          WHEEL_SINGLE: wheel[k] = (k == hot) ? WEIGHT_W'($urandom_range(255, 1)) : '0;
          WHEEL_MAX:    wheel[k] = '1;
          default:      wheel[k] = ($urandom_range(99) < 85) ? '0
                                                             : WEIGHT_W'($urandom_range(255));
        endcase
      end
      load_weights(wheel);
      calm <= (phase == 2);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 15) begin
          send_beat(KIND_SEED, $urandom);
        end else begin
          send_beat(KIND_DRAW, $urandom);
        end
        if ($urandom_range(199) == 0) settle();
      end
    end

    settle();
    if (errors == 0 && pending == 0) begin
      $display("tb_weighted_random_selector: done, clean");
    end else begin
      $display("tb_weighted_random_selector: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/wrs_pkg.sv
sv/wrs_mod.sv
sv/weighted_random_selector.sv
test/wrs_pick_checker.sv
test/tb_weighted_random_selector.sv
